// ===== hw/rtl/ftbc_pkg.sv =====
package ftbc_pkg;

  localparam int FRACTION_BITS_DEF = 8;
  localparam int COLOR_W = 8;
  localparam int NUM_CH = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam int CH_BLUE = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED = 2;

endpackage

// ===== hw/rtl/ftbc_if.sv =====
interface ftbc_smp_if
  import ftbc_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [COLOR_W-1:0]       sample_blue;
  logic [COLOR_W-1:0]       sample_green;
  logic [COLOR_W-1:0]       sample_red;
  logic [FRACTION_BITS:0]   sample_opacity;
  logic                     last_sample;

  modport source (
    output valid, sample_blue, sample_green, sample_red, sample_opacity, last_sample,
    input  ready
  );
  modport sink (
    input  valid, sample_blue, sample_green, sample_red, sample_opacity, last_sample,
    output ready
  );
endinterface

interface ftbc_pix_if
  import ftbc_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [COLOR_W-1:0]       pixel_blue;
  logic [COLOR_W-1:0]       pixel_green;
  logic [COLOR_W-1:0]       pixel_red;
  logic [FRACTION_BITS:0]   ray_opacity;
  logic                     terminated_early;

  modport source (
    output valid, pixel_blue, pixel_green, pixel_red, ray_opacity, terminated_early,
    input  ready
  );
  modport sink (
    input  valid, pixel_blue, pixel_green, pixel_red, ray_opacity, terminated_early,
    output ready
  );
endinterface

// ===== hw/rtl/ftbc_queue.sv =====
module ftbc_queue
  import ftbc_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");
  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not grow on push");
  a_count_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("queue count did not shrink on pop");
`endif

endmodule

// ===== hw/rtl/ftbc_front.sv =====
module ftbc_front
  import ftbc_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int ITEM_W = NUM_CH * COLOR_W + FRACTION_BITS + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  ftbc_smp_if.sink          smp,
  output logic              q_valid,
  input  logic              q_ready,
  output logic [ITEM_W-1:0] q_data
);

  localparam int OPA_W = FRACTION_BITS + 1;
  localparam logic [OPA_W-1:0] ONE_FX = {1'b1, {FRACTION_BITS{1'b0}}};

  logic [OPA_W-1:0]  opa_clamped;
  logic [ITEM_W-1:0] item;

  // Opacities above one are clamped to fully opaque before queuing.
  assign opa_clamped = (smp.sample_opacity > ONE_FX) ? ONE_FX : smp.sample_opacity;
  assign item = {smp.sample_blue, smp.sample_green, smp.sample_red,
                 opa_clamped, smp.last_sample};

  ftbc_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (smp.valid),
    .push_ready (smp.ready),
    .push_data  (item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

endmodule

// ===== hw/rtl/ftbc_back.sv =====
module ftbc_back
  import ftbc_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int ITEM_W = NUM_CH * COLOR_W + FRACTION_BITS + 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [FRACTION_BITS:0] cfg_wdata,
  input  logic               q_valid,
  output logic               q_ready,
  input  logic [ITEM_W-1:0]  q_data,
  ftbc_pix_if.source         pix
);

  localparam int F      = FRACTION_BITS;
  localparam int OPA_W  = F + 1;
  localparam int T_W    = 2 * F + 2;
  localparam int ACC_W  = F + COLOR_W;
  localparam int SUM_W  = ACC_W + 1;
  localparam int PROD_W = T_W + COLOR_W;
  localparam logic [OPA_W-1:0] ONE_FX  = {1'b1, {F{1'b0}}};
  localparam logic [OPA_W-1:0] THR_RST = OPA_W'((95 << F) / 100);

  logic [OPA_W-1:0]   thr_r;
  logic               back_run;

  logic [COLOR_W-1:0] q_col [NUM_CH];
  logic [OPA_W-1:0]   q_opa;
  logic               q_last;

  logic [OPA_W-1:0]   alpha_r, alpha_nxt;
  logic               sat_r, sat_nxt;
  logic [OPA_W-1:0]   one_minus;
  logic [T_W-1:0]     t_w;
  logic [F+1:0]       alpha_sum;
  logic [OPA_W-1:0]   alpha_clamp;
  logic [OPA_W-1:0]   alpha_new;
  logic               sat_new;

  logic               s1_valid_r;
  logic [T_W-1:0]     s1_t_r;
  logic [COLOR_W-1:0] s1_col_r [NUM_CH];
  logic               s1_acc_r;
  logic               s1_last_r;
  logic [OPA_W-1:0]   s1_alpha_r;
  logic               s1_sat_r;

  logic [ACC_W-1:0]   acc_r   [NUM_CH];
  logic [ACC_W-1:0]   acc_new [NUM_CH];

  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_col_r [NUM_CH];
  logic [OPA_W-1:0]   out_opa_r;
  logic               out_term_r;
  logic               out_load;

  assign {q_col[CH_BLUE], q_col[CH_GREEN], q_col[CH_RED], q_opa, q_last} = q_data;

  assign back_run = !out_valid_r || pix.ready;
  assign q_ready  = back_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RST;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // The opacity recurrence is combinational around alpha_r: one narrow multiply and an add.
  always_comb begin
    one_minus   = ONE_FX - alpha_r;
    t_w         = T_W'(one_minus) * T_W'(q_opa);
    alpha_sum   = (F + 2)'(alpha_r) + t_w[T_W-1:F];
    alpha_clamp = (alpha_sum > (F + 2)'(ONE_FX)) ? ONE_FX : alpha_sum[OPA_W-1:0];
    alpha_new   = sat_r ? alpha_r : alpha_clamp;
    sat_new     = sat_r || (alpha_clamp > thr_r);
  end

  always_comb begin
    alpha_nxt = alpha_r;
    sat_nxt   = sat_r;
    if (q_valid && back_run) begin
      alpha_nxt = q_last ? '0 : alpha_new;
      sat_nxt   = q_last ? 1'b0 : sat_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r    <= '0;
      sat_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      alpha_r <= alpha_nxt;
      sat_r   <= sat_nxt;
      if (back_run) begin
        s1_valid_r <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && back_run) begin
      s1_t_r     <= t_w;
      s1_col_r   <= q_col;
      s1_acc_r   <= !sat_r;
      s1_last_r  <= q_last;
      s1_alpha_r <= alpha_new;
      s1_sat_r   <= sat_new;
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    logic [ACC_W-1:0]  acc_sat;

    always_comb begin
      prod       = PROD_W'(s1_t_r) * PROD_W'(s1_col_r[c]);
      sum        = SUM_W'(acc_r[c]) + SUM_W'(prod[PROD_W-1:F]);
      acc_sat    = sum[SUM_W-1] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
      acc_new[c] = s1_acc_r ? acc_sat : acc_r[c];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_r[c] <= '0;
      end else if (s1_valid_r && back_run) begin
        acc_r[c] <= s1_last_r ? '0 : acc_new[c];
      end
    end

    always_ff @(posedge clk) begin
      if (out_load) begin
        out_col_r[c] <= acc_new[c][F+COLOR_W-1:F];
      end
    end
  end

  assign out_load = s1_valid_r && s1_last_r && back_run;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (pix.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_opa_r  <= s1_alpha_r;
      out_term_r <= s1_sat_r;
    end
  end

  assign pix.valid            = out_valid_r;
  assign pix.pixel_blue       = out_col_r[CH_BLUE];
  assign pix.pixel_green      = out_col_r[CH_GREEN];
  assign pix.pixel_red        = out_col_r[CH_RED];
  assign pix.ray_opacity      = out_opa_r;
  assign pix.terminated_early = out_term_r;

`ifndef SYNTH
  a_alpha_bound: assert property (@(posedge clk) disable iff (!rst_n)
    alpha_r <= ONE_FX)
    else $error("accumulated opacity above one");
  a_sat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (alpha_r != '0))
    else $error("ray terminated with zero opacity");
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("last sample of a ray produced no pixel");
  a_ray_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && back_run && q_last) |=> (alpha_r == '0 && !sat_r))
    else $error("ray state not cleared after last sample");
`endif

endmodule

// ===== hw/rtl/front_to_back_ray_compositor.sv =====
// Front-to-back compositor for the classified samples of one ray, with early
// ray termination. Each sample word brings a blue, green and red value and an
// opacity in unsigned fixed point with FRACTION_BITS fraction bits. The block
// sustains one sample per cycle while no pixel word is held back; that rate
// is set by the opacity recurrence in the back end, one narrow multiply and
// add per cycle. A pixel word is presented once the last sample of its ray
// has passed the input queue and the stage register for the opacity weight,
// after which the color accumulation is written straight into the output
// register. A pixel word that is not taken stalls the back end, and the
// two-word queue then fills and stalls the input. Once the accumulated
// opacity exceeds the threshold register, further samples of that ray are
// ignored, but the last sample still yields the pixel and clears the ray. The
// threshold resets to 0.95 and may be written only while no ray is in flight.
module front_to_back_ray_compositor
  import ftbc_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [FRACTION_BITS:0] cfg_wdata,
  ftbc_smp_if.sink               in_smp,
  ftbc_pix_if.source             out_pix
);

  localparam int ITEM_W = NUM_CH * COLOR_W + FRACTION_BITS + 2;

  logic              q_valid;
  logic              q_ready;
  logic [ITEM_W-1:0] q_data;

  ftbc_front #(
    .FRACTION_BITS (FRACTION_BITS),
    .ITEM_W        (ITEM_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .smp     (in_smp),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  ftbc_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .ITEM_W        (ITEM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .pix       (out_pix)
  );

endmodule
